### hw/rtl/i2c_master_command_sequencer_unit_assert.svh
`ifndef I2C_MASTER_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define I2C_MCS_ASSERT(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define I2C_MCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/i2c_mcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2c_mcs_pkg;

	// Default number of queued commands
	localparam int unsigned QUEUE_DEPTH_DEF = 32;

	// Input beat operations
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	// Bus status codes, compared after masking
	localparam logic [7:0] STATUS_MASK     = 8'hF8;
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_REPSTART     = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
	localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
	localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
	localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

	// Bus actions
	localparam logic [3:0] ACT_NONE      = 4'd0;
	localparam logic [3:0] ACT_START     = 4'd1;
	localparam logic [3:0] ACT_REPSTART  = 4'd2;
	localparam logic [3:0] ACT_SEND      = 4'd3;
	localparam logic [3:0] ACT_SEND_MEM  = 4'd4;
	localparam logic [3:0] ACT_RECV_ACK  = 4'd5;
	localparam logic [3:0] ACT_RECV_NACK = 4'd6;
	localparam logic [3:0] ACT_STOP      = 4'd7;

	// Callbacks
	localparam logic [1:0] CB_NONE  = 2'd0;
	localparam logic [1:0] CB_STOP  = 2'd1;
	localparam logic [1:0] CB_ERROR = 2'd2;

	// One queued command
	typedef struct packed {
		logic        is_write;
		logic        hard_stop;
		logic [1:0]  inline_count;
		logic [7:0]  target;
		logic [7:0]  byte_a;
		logic [7:0]  byte_b;
		logic [7:0]  byte_c;
		logic [15:0] addr;
		logic [7:0]  len;
	} cmd_t;

	// Queue control from the sequencer
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} q_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/i2c_mcs_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_command_sequencer_unit_assert.svh"

module i2c_mcs_cmd_queue #(
	parameter int unsigned DEPTH = i2c_mcs_pkg::QUEUE_DEPTH_DEF,
	localparam int unsigned PW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire i2c_mcs_pkg::q_ctl_t ctl,
	input  wire i2c_mcs_pkg::cmd_t  wr_data,
	output i2c_mcs_pkg::cmd_t       rd_data,
	output logic [CW-1:0]           count
);

	logic [PW-1:0]     head_q;
	logic [PW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	i2c_mcs_pkg::cmd_t mem [DEPTH];
	i2c_mcs_pkg::cmd_t rd_data_q;

	// Advance pointers and fill level; clear drops everything queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (ctl.clear) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
			end
			if (ctl.pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
			end
			// Net change of the fill level
			count_q <= count_q + CW'(ctl.push) - CW'(ctl.pop);
		end
	end

	// Write at the tail; read the head every cycle, old data on a same-entry write
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wr_data;
		end
		rd_data_q <= mem[head_q];
	end

	assign rd_data = rd_data_q;
	assign count   = count_q;

	`I2C_MCS_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "queue overfilled")
	`I2C_MCS_ASSERT(a_no_push_full, clk, arst_n, !(ctl.push && count_q == CW'(DEPTH)), "push while full")
	`I2C_MCS_ASSERT(a_no_pop_empty, clk, arst_n, !(ctl.pop && count_q == '0), "pop while empty")
	`I2C_MCS_ASSERT_NEXT(a_clear_empties, clk, arst_n, ctl.clear, count_q == '0, "clear left entries")

endmodule

`default_nettype wire

### hw/rtl/i2c_master_command_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The first result beat is presented in S_OUT0, after the accepted beat is worked out in S_EXEC.
// A new input beat is taken only once the result beats of the last item, one or two, are delivered;
// output stalls hold them. This is the accept / execute / deliver sequence around the command queue read port.
// The command queue is a memory with a registered head read; a push onto an empty queue
// that starts at once takes the command straight from the input beat.
// Reset (arst_n, asynchronous): queue empty, no active command, phase idle, codes zero.

`include "i2c_master_command_sequencer_unit_assert.svh"

module i2c_master_command_sequencer_unit #(
	parameter int unsigned QUEUE_DEPTH = i2c_mcs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic        cmd_write,
	input  wire logic        cmd_force_stop,
	input  wire logic [1:0]  cmd_inline_count,
	input  wire logic [7:0]  cmd_target,
	input  wire logic [7:0]  cmd_byte_a,
	input  wire logic [7:0]  cmd_byte_b,
	input  wire logic [7:0]  cmd_byte_c,
	input  wire logic [15:0] cmd_mem_address,
	input  wire logic [7:0]  cmd_length,
	input  wire logic [7:0]  bus_status,
	input  wire logic [7:0]  bus_rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       bus_action,
	output logic [7:0]       tx_byte,
	output logic [15:0]      mem_address,
	output logic             store_valid,
	output logic [7:0]       store_byte,
	output logic [1:0]       callback,
	output logic             push_accepted,
	output logic [5:0]       queue_free,
	output logic [7:0]       last_status,
	output logic             last
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	localparam logic [7:0] READ_BIT = 8'h01;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_START     = 4'd1;
	localparam logic [3:0] PH_SLAW      = 4'd2;
	localparam logic [3:0] PH_SLAR      = 4'd3;
	localparam logic [3:0] PH_SEND1     = 4'd4;
	localparam logic [3:0] PH_SEND2     = 4'd5;
	localparam logic [3:0] PH_SEND3     = 4'd6;
	localparam logic [3:0] PH_SENDN     = 4'd7;
	localparam logic [3:0] PH_RECV      = 4'd8;
	localparam logic [3:0] PH_RECV_LAST = 4'd9;
	localparam logic [3:0] PH_STOP      = 4'd10;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_OUT0 = 2'd2;
	localparam logic [1:0] S_OUT1 = 2'd3;

	typedef struct packed {
		logic [3:0]  action;
		logic [7:0]  tx;
		logic [15:0] addr;
		logic        sv;
		logic [7:0]  sb;
		logic [1:0]  cb;
		logic        acc;
		logic [5:0]  free;
		logic [7:0]  status;
		logic        last;
	} res_t;

	// Sequencer state
	logic [1:0]        state_q;
	logic              op_s1;
	i2c_mcs_pkg::cmd_t cmd_s1;
	logic [7:0]        status_s1;
	logic [7:0]        rx_s1;
	logic              acc_s1;
	logic              fwd_s1;
	i2c_mcs_pkg::cmd_t active_q;
	logic              active_valid_q;
	logic [3:0]        phase_q;
	logic [7:0]        exp_q;
	logic [7:0]        latest_q;
	res_t              res0_q;
	res_t              res1_q;
	logic              two_q;

	// Execute-step results
	i2c_mcs_pkg::cmd_t   in_cmd;
	i2c_mcs_pkg::cmd_t   head_cmd;
	i2c_mcs_pkg::cmd_t   q_rd_data;
	logic [CW-1:0]       q_count;
	logic [CW-1:0]       count_after;
	logic [CW-1:0]       free_w;
	i2c_mcs_pkg::q_ctl_t q_ctl;
	logic                accept;
	logic                push_ok;
	i2c_mcs_pkg::cmd_t   act_n;
	logic                act_valid_n;
	logic [3:0]          phase_n;
	logic [3:0]          nph;
	logic [7:0]          exp_n;
	logic [7:0]          latest_n;
	logic [7:0]          status_m;
	logic [7:0]          len_u;
	logic [15:0]         addr_u;
	logic                take;
	logic                take_first;
	logic                two;
	res_t                r0;
	res_t                r1;
	res_t                res_out;

	// Shape the pushed command; reads carry no inline bytes
	always_comb begin
		in_cmd.is_write     = cmd_write;
		in_cmd.hard_stop    = cmd_force_stop;
		in_cmd.inline_count = cmd_write ? cmd_inline_count : 2'd0;
		in_cmd.target       = cmd_target;
		in_cmd.byte_a       = cmd_byte_a;
		in_cmd.byte_b       = cmd_byte_b;
		in_cmd.byte_c       = cmd_byte_c;
		in_cmd.addr         = cmd_mem_address;
		in_cmd.len          = cmd_length;
	end

	assign accept   = in_valid && !in_stall;
	assign push_ok  = (opcode == i2c_mcs_pkg::OP_PUSH) && (q_count < DEPTH_C);
	assign in_stall = (state_q != S_IDLE);

	// Forward the input beat when the queue was empty at the push
	assign head_cmd = fwd_s1 ? cmd_s1 : q_rd_data;

	// Work out one item: bus action, next phase and queue update
	always_comb begin
		r0          = '0;
		r1          = '0;
		two         = 1'b0;
		take        = 1'b0;
		take_first  = 1'b0;
		act_n       = active_q;
		act_valid_n = active_valid_q;
		phase_n     = phase_q;
		exp_n       = exp_q;
		latest_n    = latest_q;
		status_m    = status_s1 & i2c_mcs_pkg::STATUS_MASK;
		len_u       = active_q.len;
		addr_u      = active_q.addr;
		nph         = PH_IDLE;
		q_ctl.push  = accept && push_ok;
		q_ctl.pop   = 1'b0;
		q_ctl.clear = 1'b0;

		if (op_s1 == i2c_mcs_pkg::OP_PUSH) begin
			r0.acc = acc_s1;
			if (acc_s1 && !active_valid_q) begin
				take       = 1'b1;
				take_first = 1'b1;
			end
		end else begin
			latest_n = status_m;
			if (status_m != exp_q) begin
				q_ctl.clear = (state_q == S_EXEC);
				r0.action   = i2c_mcs_pkg::ACT_STOP;
				r0.cb       = i2c_mcs_pkg::CB_ERROR;
				act_valid_n = 1'b0;
				phase_n     = PH_IDLE;
			end else if (!active_valid_q) begin
				phase_n = PH_IDLE;
			end else begin
				// Store a received byte
				if (phase_q == PH_RECV || phase_q == PH_RECV_LAST) begin
					r0.sv   = 1'b1;
					r0.sb   = rx_s1;
					r0.addr = active_q.addr;
					addr_u  = active_q.addr + 16'd1;
					len_u   = active_q.len - 8'd1;
				end
				unique case (phase_q)
					PH_START: begin
						nph = active_q.is_write ? PH_SLAW : PH_SLAR;
					end
					PH_SLAR, PH_RECV: begin
						nph = (len_u > 8'd1) ? PH_RECV : PH_RECV_LAST;
					end
					PH_RECV_LAST: begin
						nph = PH_STOP;
					end
					PH_SLAW: begin
						if (active_q.inline_count != 2'd0) nph = PH_SEND1;
						else nph = (len_u != 8'd0) ? PH_SENDN : PH_STOP;
					end
					PH_SEND1: begin
						nph = (active_q.inline_count == 2'd1) ? PH_STOP : PH_SEND2;
					end
					PH_SEND2: begin
						nph = (active_q.inline_count == 2'd2) ? PH_STOP : PH_SEND3;
					end
					PH_SEND3: begin
						nph = PH_STOP;
					end
					PH_SENDN: begin
						nph = (len_u != 8'd0) ? PH_SENDN : PH_STOP;
					end
					default: begin
						nph = PH_IDLE;
					end
				endcase
				phase_n    = nph;
				act_n.addr = addr_u;
				act_n.len  = len_u;
				unique case (nph)
					PH_SLAR: begin
						r0.action = i2c_mcs_pkg::ACT_SEND;
						r0.tx     = active_q.target | READ_BIT;
						exp_n     = i2c_mcs_pkg::ST_SLAR_ACK;
					end
					PH_SLAW: begin
						r0.action = i2c_mcs_pkg::ACT_SEND;
						r0.tx     = active_q.target;
						exp_n     = i2c_mcs_pkg::ST_SLAW_ACK;
					end
					PH_RECV, PH_RECV_LAST: begin
						if (len_u == 8'd1) begin
							r0.action = i2c_mcs_pkg::ACT_RECV_NACK;
							exp_n     = i2c_mcs_pkg::ST_DATA_RX_NACK;
						end else begin
							r0.action = i2c_mcs_pkg::ACT_RECV_ACK;
							exp_n     = i2c_mcs_pkg::ST_DATA_RX_ACK;
						end
					end
					PH_SEND1: begin
						r0.action = i2c_mcs_pkg::ACT_SEND;
						r0.tx     = active_q.byte_a;
						exp_n     = i2c_mcs_pkg::ST_DATA_TX_ACK;
					end
					PH_SEND2: begin
						r0.action = i2c_mcs_pkg::ACT_SEND;
						r0.tx     = active_q.byte_b;
						exp_n     = i2c_mcs_pkg::ST_DATA_TX_ACK;
					end
					PH_SEND3: begin
						r0.action = i2c_mcs_pkg::ACT_SEND;
						r0.tx     = active_q.byte_c;
						exp_n     = i2c_mcs_pkg::ST_DATA_TX_ACK;
					end
					PH_SENDN: begin
						r0.action  = i2c_mcs_pkg::ACT_SEND_MEM;
						r0.addr    = addr_u;
						act_n.addr = addr_u + 16'd1;
						act_n.len  = len_u - 8'd1;
						exp_n      = i2c_mcs_pkg::ST_DATA_TX_ACK;
					end
					PH_STOP: begin
						if (q_count == '0) begin
							r0.action   = i2c_mcs_pkg::ACT_STOP;
							r0.cb       = i2c_mcs_pkg::CB_STOP;
							exp_n       = 8'd0;
							act_valid_n = 1'b0;
							phase_n     = PH_IDLE;
						end else if (active_q.hard_stop) begin
							// Stop, then start the next command in a second beat
							r0.action  = i2c_mcs_pkg::ACT_STOP;
							r1.cb      = i2c_mcs_pkg::CB_STOP;
							two        = 1'b1;
							take       = 1'b1;
							take_first = 1'b1;
						end else begin
							r0.cb = i2c_mcs_pkg::CB_STOP;
							take  = 1'b1;
						end
					end
					default: begin
						act_valid_n = 1'b0;
						phase_n     = PH_IDLE;
					end
				endcase
			end
		end

		// Take the oldest queued command
		if (take) begin
			q_ctl.pop   = (state_q == S_EXEC);
			act_n       = head_cmd;
			act_valid_n = 1'b1;
			phase_n     = PH_START;
			exp_n       = take_first ? i2c_mcs_pkg::ST_START : i2c_mcs_pkg::ST_REPSTART;
			if (two) r1.action = i2c_mcs_pkg::ACT_START;
			else r0.action = take_first ? i2c_mcs_pkg::ACT_START : i2c_mcs_pkg::ACT_REPSTART;
		end

		count_after = (op_s1 != i2c_mcs_pkg::OP_PUSH && status_m != exp_q) ? '0 :
			(take ? q_count - CW'(1) : q_count);
		free_w      = DEPTH_C - count_after;
		r0.free     = 6'(free_w);
		r1.free     = 6'(free_w);
		r0.status   = latest_n;
		r1.status   = latest_n;
		r0.last     = !two;
		r1.last     = 1'b1;
	end

	// Command queue
	i2c_mcs_cmd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (q_ctl),
		.wr_data (in_cmd),
		.rd_data (q_rd_data),
		.count   (q_count)
	);

	// Sequence accept, execute and result beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			active_valid_q <= 1'b0;
			phase_q        <= PH_IDLE;
			exp_q          <= 8'd0;
			latest_q       <= 8'd0;
			two_q          <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					active_valid_q <= act_valid_n;
					phase_q        <= phase_n;
					exp_q          <= exp_n;
					latest_q       <= latest_n;
					two_q          <= two;
					state_q        <= S_OUT0;
				end
				S_OUT0: begin
					if (!out_stall) state_q <= two_q ? S_OUT1 : S_IDLE;
				end
				S_OUT1: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted beat and the item's payload results
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= opcode;
			cmd_s1    <= in_cmd;
			status_s1 <= bus_status;
			rx_s1     <= bus_rx_byte;
			acc_s1    <= push_ok;
			fwd_s1    <= push_ok && (q_count == '0);
		end
		if (state_q == S_EXEC) begin
			active_q <= act_n;
			res0_q   <= r0;
			res1_q   <= r1;
		end
	end

	// Drive the result beat
	assign res_out       = (state_q == S_OUT1) ? res1_q : res0_q;
	assign out_valid     = (state_q == S_OUT0) || (state_q == S_OUT1);
	assign bus_action    = res_out.action;
	assign tx_byte       = res_out.tx;
	assign mem_address   = res_out.addr;
	assign store_valid   = res_out.sv;
	assign store_byte    = res_out.sb;
	assign callback      = res_out.cb;
	assign push_accepted = res_out.acc;
	assign queue_free    = res_out.free;
	assign last_status   = res_out.status;
	assign last          = res_out.last;

	`I2C_MCS_ASSERT(a_no_overlap, clk, arst_n, !(out_valid && !in_stall), "input taken during output")
	`I2C_MCS_ASSERT(a_idle_phase, clk, arst_n, active_valid_q || phase_q == PH_IDLE, "phase without command")
	`I2C_MCS_ASSERT(a_second_beat, clk, arst_n, state_q != S_OUT1 || two_q, "second beat without cause")
	`I2C_MCS_ASSERT_NEXT(a_exec_out, clk, arst_n, state_q == S_EXEC, state_q == S_OUT0, "execute not followed by result")

endmodule

`default_nettype wire
